/* hw/rtl/q16d_pkg.sv */
// q16d_pkg: shared constants and the per-stage work record of the q16.16 divider
// no dependencies; imported by the step module and the top level
`default_nettype none

package q16d_pkg;

  localparam int WORD_W = 32;
  localparam int FRAC_W = 16;
  localparam int NUM_W = WORD_W + FRAC_W;
  localparam int QBITS = WORD_W - 1;
  localparam int HEAD_W = NUM_W - QBITS;

  localparam logic [WORD_W-1:0] Q_MAX_POS = 32'h7fff_ffff;
  localparam logic [WORD_W-1:0] Q_MIN_NEG = 32'h8000_0000;

  typedef struct packed {
    logic              valid;
    logic [WORD_W-1:0] rem;
    logic [QBITS-1:0]  low;
    logic [WORD_W-1:0] dvs;
    logic              negate;
    logic              neg_a;
    logic              ovf;
    logic              zdiv;
  } q16d_work_t;

endpackage

`default_nettype wire

/* hw/rtl/q16d_in_if.sv */
// q16d_in_if: operand channel of the q16.16 divider, valid/ready handshake
// no dependencies
`default_nettype none

interface q16d_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] dividend;
  logic signed [31:0] divisor;

  modport source (output valid, output dividend, output divisor, input ready);
  modport sink (input valid, input dividend, input divisor, output ready);
endinterface

`default_nettype wire

/* hw/rtl/q16d_out_if.sv */
// q16d_out_if: result channel of the q16.16 divider, valid/ready handshake
// no dependencies
`default_nettype none

interface q16d_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] quotient;
  logic               saturated;
  logic               zero_divisor;

  modport source (output valid, output quotient, output saturated, output zero_divisor,
                  input ready);
  modport sink (input valid, input quotient, input saturated, input zero_divisor,
                output ready);
endinterface

`default_nettype wire

/* hw/rtl/q16d_step.sv */
// q16d_step: one registered restoring division step (one quotient bit)
// depends on q16d_pkg
`default_nettype none

module q16d_step (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 adv,
  input  wire q16d_pkg::q16d_work_t d,
  output q16d_pkg::q16d_work_t      q
);
  import q16d_pkg::*;

  logic [WORD_W:0]   trial;
  logic              ge;
  logic [WORD_W:0]   diff;
  q16d_work_t        nxt;
  q16d_work_t        work_r;

  always_comb begin
    trial = {d.rem, d.low[QBITS-1]};
    ge    = trial >= {1'b0, d.dvs};
    diff  = trial - {1'b0, d.dvs};
    nxt   = d;
    nxt.rem = ge ? diff[WORD_W-1:0] : trial[WORD_W-1:0];
    nxt.low = {d.low[QBITS-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      work_r.valid <= 1'b0;
    end else if (adv) begin
      work_r.valid <= nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      work_r.rem    <= nxt.rem;
      work_r.low    <= nxt.low;
      work_r.dvs    <= nxt.dvs;
      work_r.negate <= nxt.negate;
      work_r.neg_a  <= nxt.neg_a;
      work_r.ovf    <= nxt.ovf;
      work_r.zdiv   <= nxt.zdiv;
    end
  end

  assign q = work_r;

endmodule

`default_nettype wire

/* hw/rtl/q16_16_saturating_divide.sv */
// q16_16_saturating_divide: pipelined signed q16.16 divider with rounding and saturation
// depends on q16d_pkg, q16d_in_if, q16d_out_if and q16d_step
//
// usage:
//   in_ch carries a dividend/divisor pair, out_ch carries quotient, saturated
//   and zero_divisor; an item moves when valid and ready are both high.
//   the quotient is round(|a| * 2^16 / |b|) with the sign of a xor b, clamped
//   to 0x7fffffff / 0x80000000 on overflow (saturated) or on a zero divisor
//   (zero_divisor, clamp follows the dividend sign).
// stages: one magnitude stage, one numerator/overflow stage, 31 restoring steps
//   (one quotient bit each, one 33-bit subtract and compare per stage) and one
//   sign/clamp output stage, all registered, between acceptance and out_ch.
// throughput: one item per cycle while out_ch does not stall; in_ch.ready is high
//   whenever the output register is empty or being taken.
// stall: when out_ch.ready is low with a result waiting, the whole pipe holds
//   and in_ch.ready drops; nothing is lost or repeated.
// reset: synchronous rst_n clears all valid bits; no item is in flight after.
`default_nettype none

module q16_16_saturating_divide (
  input  wire logic   clk,
  input  wire logic   rst_n,
  q16d_in_if.sink     in_ch,
  q16d_out_if.source  out_ch
);
  import q16d_pkg::*;

  logic              adv;

  logic              s0_valid_r;
  logic [WORD_W-1:0] s0_mag_a_r;
  logic [WORD_W-1:0] s0_mag_b_r;
  logic              s0_neg_a_r;
  logic              s0_neg_b_r;
  logic [WORD_W-1:0] mag_a_nxt;
  logic [WORD_W-1:0] mag_b_nxt;

  logic [NUM_W-1:0]  num;
  q16d_work_t        init_nxt;
  q16d_work_t        w [0:QBITS];

  logic              out_valid_r;
  logic [WORD_W-1:0] out_q_r;
  logic              out_sat_r;
  logic              out_zdiv_r;
  logic [WORD_W-1:0] out_q_nxt;
  logic [WORD_W-1:0] mag_q;
  logic [WORD_W-1:0] clamp;

  assign adv         = !out_valid_r || out_ch.ready;
  assign in_ch.ready = adv;

  // magnitudes
  always_comb begin
    mag_a_nxt = in_ch.dividend[WORD_W-1] ? (~in_ch.dividend + WORD_W'(1)) : in_ch.dividend;
    mag_b_nxt = in_ch.divisor[WORD_W-1] ? (~in_ch.divisor + WORD_W'(1)) : in_ch.divisor;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (adv) begin
      s0_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_mag_a_r <= mag_a_nxt;
      s0_mag_b_r <= mag_b_nxt;
      s0_neg_a_r <= in_ch.dividend[WORD_W-1];
      s0_neg_b_r <= in_ch.divisor[WORD_W-1];
    end
  end

  // rounded numerator and overflow test on the head bits
  always_comb begin
    num = {s0_mag_a_r, {FRAC_W{1'b0}}} + {{(FRAC_W+1){1'b0}}, s0_mag_b_r[WORD_W-1:1]};
    init_nxt.valid  = s0_valid_r;
    init_nxt.ovf    = {{(WORD_W-HEAD_W){1'b0}}, num[NUM_W-1:QBITS]} >= s0_mag_b_r;
    init_nxt.rem    = {{(WORD_W-HEAD_W){1'b0}}, num[NUM_W-1:QBITS]};
    init_nxt.low    = num[QBITS-1:0];
    init_nxt.dvs    = s0_mag_b_r;
    init_nxt.negate = s0_neg_a_r ^ s0_neg_b_r;
    init_nxt.neg_a  = s0_neg_a_r;
    init_nxt.zdiv   = s0_mag_b_r == '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w[0].valid <= 1'b0;
    end else if (adv) begin
      w[0].valid <= init_nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      w[0].rem    <= init_nxt.rem;
      w[0].low    <= init_nxt.low;
      w[0].dvs    <= init_nxt.dvs;
      w[0].negate <= init_nxt.negate;
      w[0].neg_a  <= init_nxt.neg_a;
      w[0].ovf    <= init_nxt.ovf;
      w[0].zdiv   <= init_nxt.zdiv;
    end
  end

  for (genvar i = 0; i < QBITS; i++) begin : g_step
    q16d_step u_step (
      .clk   (clk),
      .rst_n (rst_n),
      .adv   (adv),
      .d     (w[i]),
      .q     (w[i+1])
    );
  end

  // sign and clamp
  always_comb begin
    mag_q = {1'b0, w[QBITS].low};
    if (w[QBITS].zdiv) begin
      clamp = w[QBITS].neg_a ? Q_MIN_NEG : Q_MAX_POS;
    end else begin
      clamp = w[QBITS].negate ? Q_MIN_NEG : Q_MAX_POS;
    end
    if (w[QBITS].zdiv || w[QBITS].ovf) begin
      out_q_nxt = clamp;
    end else if (w[QBITS].negate) begin
      out_q_nxt = ~mag_q + WORD_W'(1);
    end else begin
      out_q_nxt = mag_q;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= w[QBITS].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_q_r    <= out_q_nxt;
      out_sat_r  <= w[QBITS].ovf && !w[QBITS].zdiv;
      out_zdiv_r <= w[QBITS].zdiv;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.quotient     = out_q_r;
  assign out_ch.saturated    = out_sat_r;
  assign out_ch.zero_divisor = out_zdiv_r;

endmodule

`default_nettype wire
